FILE: design/hexc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hexc_pkg
// Shared types, constants and the tanh table generator for the exciter core.
// ----------------------------------------------------------------------------
package hexc_pkg;

    localparam int DefMaxChannels = 8;
    localparam int DefTanhEntries = 256;

    // fixed formats of the datapath
    localparam int SampleW = 24;
    localparam int GainW   = 16;
    localparam int ChanW   = 3;
    localparam int CfgIdxW = 4;
    localparam int TanhQ   = 30;     // fixed point of the table generator
    localparam int SpanLog2 = 26;    // |u| * N >> SpanLog2 gives the table index

    localparam logic [CfgIdxW-1:0] RegHpGain  = 4'd0;
    localparam logic [CfgIdxW-1:0] RegHpFb1   = 4'd1;
    localparam logic [CfgIdxW-1:0] RegHpFb2   = 4'd2;
    localparam logic [CfgIdxW-1:0] RegLpGain  = 4'd3;
    localparam logic [CfgIdxW-1:0] RegLpFb1   = 4'd4;
    localparam logic [CfgIdxW-1:0] RegLpFb2   = 4'd5;
    localparam logic [CfgIdxW-1:0] RegDrive   = 4'd6;
    localparam logic [CfgIdxW-1:0] RegWetGain = 4'd7;

    typedef enum logic [17:0] {
        S_IDLE = 18'b000000000000000001,
        S_HP0  = 18'b000000000000000010,
        S_HP1  = 18'b000000000000000100,
        S_HP2  = 18'b000000000000001000,
        S_HPY  = 18'b000000000000010000,
        S_DRV  = 18'b000000000000100000,
        S_MAG  = 18'b000000000001000000,
        S_IDX  = 18'b000000000010000000,
        S_TB0  = 18'b000000000100000000,
        S_TB1  = 18'b000000001000000000,
        S_INT  = 18'b000000010000000000,
        S_SIDE = 18'b000000100000000000,
        S_LP0  = 18'b000001000000000000,
        S_LP1  = 18'b000010000000000000,
        S_LP2  = 18'b000100000000000000,
        S_LPY  = 18'b001000000000000000,
        S_WET  = 18'b010000000000000000,
        S_FIN  = 18'b100000000000000000
    } t_state;

    // Unsigned shift-and-subtract quotient, used only at elaboration.
    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i of the tanh table: tanh(8*i/N) in Q1.23, evaluated at
    // elaboration. step is 16/N in Q30; exp(-2*8/N) comes from a series,
    // and e = exp(-16*i/N) is stepped up i times.
    function automatic logic [23:0] tanh_entry(longint unsigned step, int i);
        longint unsigned one;
        longint unsigned term;
        longint signed   r;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned t;
        longint unsigned kk;
        one  = 64'd1 << TanhQ;
        term = one;
        r    = longint'(one);
        e    = one;
        for (int k = 1; k <= 24; k++) begin
            kk   = longint'(k);
            term = udiv((term * step) >> TanhQ, kk);
            if ((k & 1) == 1) begin
                r = r - longint'(term);
            end else begin
                r = r + longint'(term);
            end
        end
        for (int j = 0; j < i; j++) begin
            e = (e * longint'(unsigned'(r)) + (one >> 1)) >> TanhQ;
        end
        num = (one - e) << 23;
        den = one + e;
        t   = udiv(num + (den >> 1), den);
        if (t > 64'd8388607) begin
            t = 64'd8388607;
        end
        return t[23:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/harmonic_exciter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// harmonic_exciter_core
// Per-channel audio exciter: high-pass, drive, tanh saturation, low-pass, mix.
// ----------------------------------------------------------------------------
// One sample word enters with its channel index and one result word leaves.
// The word runs through the channel's high-pass biquad, is scaled by drive,
// saturated through a linearly interpolated tanh table, filtered by the
// channel's low-pass biquad, and added back to the dry sample through
// wet_gain with 24-bit saturation. All multiplies go through one shared
// 29x27 multiply-accumulate unit stepped by a one-hot sequencer, and the
// result is registered as the sequencer leaves its final state (the
// interpolation states are skipped when the driven value is at or beyond
// full tanh scale; a channel index at or above MAX_CHANNELS goes straight
// to the final state and passes the sample through unchanged). The core takes
// one word at a time; the result sits in an output register, and the next
// word is taken as soon as the sequencer is back in idle, so a word occupies
// the core until then, plus any wait for a free output register. Configuration
// words are accepted every cycle and must only be written while idle.
// ----------------------------------------------------------------------------
module harmonic_exciter_core
    import hexc_pkg::*;
#(
    parameter int MAX_CHANNELS       = DefMaxChannels,
    parameter int TANH_TABLE_ENTRIES = DefTanhEntries
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // sample input
    input  wire logic                       i_valid,
    output      logic                       o_ready,
    input  wire logic signed [SampleW-1:0]  i_sample_in,
    input  wire logic        [ChanW-1:0]    i_channel,
    // result output
    output      logic                       o_valid,
    input  wire logic                       i_ready,
    output      logic signed [SampleW-1:0]  o_sample_out,
    output      logic        [ChanW-1:0]    o_channel_out,
    // configuration writes
    input  wire logic                       i_cfg_valid,
    output      logic                       o_cfg_ready,
    input  wire logic        [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic        [SampleW-1:0]  i_cfg_data
);

    localparam int HistW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TabW  = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam longint unsigned TanhStep = (64'd16 << TanhQ) / TANH_TABLE_ENTRIES;
    localparam int AccW  = 56;

    // ------------------------------------------------------------------
    // tanh table, constant logic
    // ------------------------------------------------------------------
    logic [SampleW-1:0] w_tab [TANH_TABLE_ENTRIES+1];

    for (genvar g = 0; g <= TANH_TABLE_ENTRIES; g++) begin : g_tab
        assign w_tab[g] = tanh_entry(TanhStep, g);
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [SampleW-1:0] r_hp_gain, r_hp_fb1, r_hp_fb2;
    logic signed [SampleW-1:0] r_lp_gain, r_lp_fb1, r_lp_fb2;
    logic        [GainW-1:0]   r_drive, r_wet;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_gain <= '0;
            r_hp_fb1  <= '0;
            r_hp_fb2  <= '0;
            r_lp_gain <= '0;
            r_lp_fb1  <= '0;
            r_lp_fb2  <= '0;
            r_drive   <= GainW'(4096);
            r_wet     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegHpGain:  r_hp_gain <= i_cfg_data;
                RegHpFb1:   r_hp_fb1  <= i_cfg_data;
                RegHpFb2:   r_hp_fb2  <= i_cfg_data;
                RegLpGain:  r_lp_gain <= i_cfg_data;
                RegLpFb1:   r_lp_fb1  <= i_cfg_data;
                RegLpFb2:   r_lp_fb2  <= i_cfg_data;
                RegDrive:   r_drive   <= i_cfg_data[GainW-1:0];
                RegWetGain: r_wet     <= i_cfg_data[GainW-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // per-channel filter history (x1, x2, y1, y2 for each biquad)
    // ------------------------------------------------------------------
    logic signed [SampleW-1:0] r_hp_x1 [MAX_CHANNELS];
    logic signed [SampleW-1:0] r_hp_x2 [MAX_CHANNELS];
    logic signed [SampleW-1:0] r_hp_y1 [MAX_CHANNELS];
    logic signed [SampleW-1:0] r_hp_y2 [MAX_CHANNELS];
    logic signed [SampleW-1:0] r_lp_x1 [MAX_CHANNELS];
    logic signed [SampleW-1:0] r_lp_x2 [MAX_CHANNELS];
    logic signed [SampleW-1:0] r_lp_y1 [MAX_CHANNELS];
    logic signed [SampleW-1:0] r_lp_y2 [MAX_CHANNELS];

    // ------------------------------------------------------------------
    // sequencer and working registers
    // ------------------------------------------------------------------
    t_state                    r_state;
    logic signed [SampleW-1:0] r_x;        // dry sample
    logic        [ChanW-1:0]   r_ch;
    logic signed [SampleW-1:0] r_x1, r_x2, r_y1, r_y2;   // history of the active biquad
    logic signed [SampleW-1:0] r_y;        // filter output, then mix operand
    logic signed [SampleW-1:0] r_s;        // saturated side signal
    logic signed [AccW-1:0]    r_acc;
    logic                      r_neg;
    logic        [27:0]        r_mag;
    logic        [TabW-1:0]    r_idx;
    logic        [SampleW-1:0] r_t0;
    logic signed [SampleW:0]   r_d;
    logic        [SpanLog2-1:0] r_frac;
    logic                      r_ovalid;
    logic signed [SampleW-1:0] r_out;
    logic        [ChanW-1:0]   r_out_ch;

    logic [HistW-1:0] w_hidx;
    logic             w_in_range;
    logic             w_accept;

    assign w_hidx     = HistW'(r_ch);
    assign w_in_range = (32'(i_channel) < 32'(MAX_CHANNELS));
    assign w_accept   = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);

    // ------------------------------------------------------------------
    // shared multiply-accumulate unit
    // ------------------------------------------------------------------
    logic signed [28:0]     m_a;
    logic signed [26:0]     m_b;
    logic signed [AccW-1:0] m_p;
    logic                   m_load, m_sub;
    logic signed [26:0]     w_hp_sum, w_lp_sum;

    assign w_hp_sum = 27'(r_x) - (27'(r_x1) <<< 1) + 27'(r_x2);
    assign w_lp_sum = 27'(r_s) + (27'(r_x1) <<< 1) + 27'(r_x2);

    always_comb begin
        m_a    = '0;
        m_b    = '0;
        m_load = 1'b0;
        m_sub  = 1'b0;
        unique case (r_state)
            S_HP0: begin m_a = 29'(w_hp_sum); m_b = 27'(r_hp_gain); m_load = 1'b1; end
            S_HP1: begin m_a = 29'(r_y1); m_b = 27'(r_hp_fb1); m_sub = 1'b1; end
            S_HP2: begin m_a = 29'(r_y2); m_b = 27'(r_hp_fb2); m_sub = 1'b1; end
            S_DRV: begin m_a = 29'(r_y); m_b = $signed({11'd0, r_drive}); m_load = 1'b1; end
            S_IDX: begin
                m_a = $signed({1'b0, r_mag});
                m_b = 27'(TANH_TABLE_ENTRIES);
                m_load = 1'b1;
            end
            S_INT: begin m_a = 29'(r_d); m_b = $signed({1'b0, r_frac}); m_load = 1'b1; end
            S_LP0: begin m_a = 29'(w_lp_sum); m_b = 27'(r_lp_gain); m_load = 1'b1; end
            S_LP1: begin m_a = 29'(r_y1); m_b = 27'(r_lp_fb1); m_sub = 1'b1; end
            S_LP2: begin m_a = 29'(r_y2); m_b = 27'(r_lp_fb2); m_sub = 1'b1; end
            S_WET: begin m_a = 29'(r_y); m_b = $signed({11'd0, r_wet}); m_load = 1'b1; end
            default: ;
        endcase
    end

    assign m_p = AccW'(m_a) * AccW'(m_b);

    // ------------------------------------------------------------------
    // rounding and saturation around the accumulator
    // ------------------------------------------------------------------
    function automatic logic signed [SampleW-1:0] sat24(logic signed [AccW-1:0] v);
        if (v > AccW'(8388607)) begin
            return SampleW'(8388607);
        end else if (v < -AccW'(8388608)) begin
            return SampleW'(-8388608);
        end
        return v[SampleW-1:0];
    endfunction

    logic signed [AccW-1:0]  w_rnd22, w_rnd12, w_rnd26, w_mix;
    logic signed [28:0]      w_u;
    logic signed [28:0]      w_uabs;
    logic signed [SampleW:0] w_t;
    logic [AccW-SpanLog2-1:0] w_pidx;

    assign w_rnd22 = (r_acc + (AccW'(1) <<< 21)) >>> 22;
    assign w_rnd12 = (r_acc + (AccW'(1) <<< 11)) >>> 12;
    assign w_rnd26 = (r_acc + (AccW'(1) <<< (SpanLog2 - 1))) >>> SpanLog2;
    assign w_u     = w_rnd12[28:0];
    assign w_uabs  = w_u[28] ? -w_u : w_u;
    assign w_t     = $signed({1'b0, r_t0}) + w_rnd26[SampleW:0];
    assign w_mix   = AccW'(r_x) + w_rnd12;
    assign w_pidx  = r_acc[AccW-1:SpanLog2];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_hp_x1[c] <= '0;
                r_hp_x2[c] <= '0;
                r_hp_y1[c] <= '0;
                r_hp_y2[c] <= '0;
                r_lp_x1[c] <= '0;
                r_lp_x2[c] <= '0;
                r_lp_y1[c] <= '0;
                r_lp_y2[c] <= '0;
            end
        end else begin
            // drop the taken word, unless the finishing word refills it
            if (r_ovalid && i_ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            if (m_load) begin
                r_acc <= m_p;
            end else if (m_sub) begin
                r_acc <= r_acc - m_p;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_x   <= i_sample_in;
                        r_ch  <= i_channel;
                        r_acc <= '0;      // pass-through path mixes in zero
                        if (w_in_range) begin
                            r_x1    <= r_hp_x1[HistW'(i_channel)];
                            r_x2    <= r_hp_x2[HistW'(i_channel)];
                            r_y1    <= r_hp_y1[HistW'(i_channel)];
                            r_y2    <= r_hp_y2[HistW'(i_channel)];
                            r_state <= S_HP0;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_HP0: r_state <= S_HP1;
                S_HP1: r_state <= S_HP2;
                S_HP2: r_state <= S_HPY;
                S_HPY: begin
                    // shift high-pass history, then load the low-pass history
                    r_y              <= sat24(w_rnd22);
                    r_hp_x2[w_hidx]  <= r_x1;
                    r_hp_x1[w_hidx]  <= r_x;
                    r_hp_y2[w_hidx]  <= r_y1;
                    r_hp_y1[w_hidx]  <= sat24(w_rnd22);
                    r_x1             <= r_lp_x1[w_hidx];
                    r_x2             <= r_lp_x2[w_hidx];
                    r_y1             <= r_lp_y1[w_hidx];
                    r_y2             <= r_lp_y2[w_hidx];
                    r_state          <= S_DRV;
                end
                S_DRV: r_state <= S_MAG;
                S_MAG: begin
                    r_neg   <= w_u[28];
                    r_mag   <= w_uabs[27:0];
                    r_state <= S_IDX;
                end
                S_IDX: r_state <= S_TB0;
                S_TB0: begin
                    if (w_pidx >= (AccW - SpanLog2)'(TANH_TABLE_ENTRIES)) begin
                        // at or past full scale: take the last entry as is
                        r_t0    <= w_tab[TANH_TABLE_ENTRIES];
                        r_acc   <= '0;
                        r_state <= S_SIDE;
                    end else begin
                        r_idx   <= r_acc[SpanLog2 +: TabW];
                        r_t0    <= w_tab[r_acc[SpanLog2 +: TabW]];
                        r_frac  <= r_acc[SpanLog2-1:0];
                        r_state <= S_TB1;
                    end
                end
                S_TB1: begin
                    r_d     <= $signed({1'b0, w_tab[r_idx + TabW'(1)]})
                             - $signed({1'b0, r_t0});
                    r_state <= S_INT;
                end
                S_INT: r_state <= S_SIDE;
                S_SIDE: begin
                    r_s     <= r_neg ? -w_t[SampleW-1:0] : w_t[SampleW-1:0];
                    r_state <= S_LP0;
                end
                S_LP0: r_state <= S_LP1;
                S_LP1: r_state <= S_LP2;
                S_LP2: r_state <= S_LPY;
                S_LPY: begin
                    r_y              <= sat24(w_rnd22);
                    r_lp_x2[w_hidx]  <= r_x1;
                    r_lp_x1[w_hidx]  <= r_s;
                    r_lp_y2[w_hidx]  <= r_y1;
                    r_lp_y1[w_hidx]  <= sat24(w_rnd22);
                    r_state          <= S_WET;
                end
                S_WET: r_state <= S_FIN;
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_ready) begin
                        r_out    <= sat24(w_mix);
                        r_out_ch <= r_ch;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_sample_out  = r_out;
    assign o_channel_out = r_out_ch;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("input taken again before the item finished");

    a_fin_publishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && (!r_ovalid || i_ready) |=> o_valid && o_ready)
        else $error("finished item not published");

    a_table_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TB1) |-> (32'(r_idx) < 32'(TANH_TABLE_ENTRIES)))
        else $error("tanh index out of range");

endmodule
`default_nettype wire
